// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the ADC scan averager.
// Depends on nothing; the SYNTH define turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER_AT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER_AT(label, clk, rst_n, cond, msg)
`endif

`endif

// File: src/asa_pkg.sv
`timescale 1ns / 1ps
// Package of the ADC scan averager: field widths, channel codes and scan order.
// Depends on nothing.
package asa_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned READINGS_PER_AVERAGE_DEF = 4;

  localparam logic [CHAN_W-1:0] CH_0 = 3'd0;
  localparam logic [CHAN_W-1:0] CH_1 = 3'd1;
  localparam logic [CHAN_W-1:0] CH_2 = 3'd2;
  localparam logic [CHAN_W-1:0] CH_3 = 3'd3;
  localparam logic [CHAN_W-1:0] CH_4 = 3'd4;
  localparam logic [CHAN_W-1:0] CH_5 = 3'd5;
  localparam logic [CHAN_W-1:0] CH_6 = 3'd6;
  localparam logic [CHAN_W-1:0] CH_7 = 3'd7;

  typedef struct packed {
    logic              stored;  // channel keeps an average
    logic [CHAN_W-1:0] next;    // channel that follows in the scan
  } scan_step_t;

  // Scan order 0,1,2,3,6,7,0. Channels 4 and 5 are not scanned and return to 0.
  function automatic scan_step_t scan_next(input logic [CHAN_W-1:0] ch);
    scan_step_t step;
    step.stored = 1'b1;
    unique case (ch)
      CH_0: step.next = CH_1;
      CH_1: step.next = CH_2;
      CH_2: step.next = CH_3;
      CH_3: step.next = CH_6;
      CH_6: step.next = CH_7;
      CH_7: step.next = CH_0;
      default: begin
        step.stored = 1'b0;
        step.next   = CH_0;
      end
    endcase
    return step;
  endfunction

endpackage

// File: src/adc_scan_averager.sv
`timescale 1ns / 1ps
// Top level of the ADC scan averager: accumulator, scan sequencer, result register.
// Depends on asa_pkg and assert_macros.svh.
//
// Usage:
// The input channel carries one converter reading per item (sample_i) under
// in_valid_i / in_stall_o. The output channel gives exactly one result item per
// input item under out_valid_o / out_stall_i: the mux channel to convert next,
// and, when a scan cycle closes on a stored channel, that channel's average.
// A cycle sums READINGS_PER_AVERAGE readings; the reading after them closes the
// cycle, is discarded, and releases sum / READINGS_PER_AVERAGE (truncated).
// Channels 4 and 5 close without an average and jump to channel 0.
// A result is registered: an item taken at one edge shows its result after it.
// Throughput is one item per cycle while out_stall_i is low; all work sits between
// the input handshake and the single result register, and the division is a
// constant reciprocal multiply feeding that register.
// When the receiver stalls, the result register holds; a new item is still
// taken in the cycle the held result leaves, so in_stall_o is high only while
// a result waits and out_stall_i is high.
// Reset clears count and sum and selects channel 0. A write on cfg_we_i loads
// cfg_data_i as the current channel at once; count and sum are kept.
`include "assert_macros.svh"

module adc_scan_averager import asa_pkg::*; #(
  parameter int unsigned READINGS_PER_AVERAGE = READINGS_PER_AVERAGE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration: start channel
  input  logic                cfg_we_i,
  input  logic [CHAN_W-1:0]   cfg_data_i,
  // Input items
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  // Result items
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CHAN_W-1:0]   next_channel_o,
  output logic                average_valid_o,
  output logic [CHAN_W-1:0]   average_channel_o,
  output logic [SAMPLE_W-1:0] average_value_o
);

  // Count runs 0, 2, 3, .. N+1; the item seen at N+1 closes the cycle.
  localparam int unsigned END_COUNT = READINGS_PER_AVERAGE + 1;
  localparam int unsigned CNT_W     = $clog2(END_COUNT + 1);
  localparam int unsigned SUM_W     = $clog2(READINGS_PER_AVERAGE * 255 + 1);
  // Reciprocal with enough fraction bits that floor(sum * RECIP >> SHIFT)
  // equals sum / N exactly for every sum below 2**SUM_W.
  localparam int unsigned SHIFT     = SUM_W + 2 * $clog2(READINGS_PER_AVERAGE + 1);
  localparam int unsigned PROD_W    = SUM_W + SHIFT + 1;
  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((64'd1 << SHIFT) + 64'(READINGS_PER_AVERAGE) - 64'd1)
            / 64'(READINGS_PER_AVERAGE));
  localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(END_COUNT);

  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic                out_valid_q;
  logic [CHAN_W-1:0]   next_chan_q, next_chan_d;
  logic                avg_valid_q, avg_valid_d;
  logic [CHAN_W-1:0]   avg_chan_q, avg_chan_d;
  logic [SAMPLE_W-1:0] avg_value_q, avg_value_d;

  logic                accept;
  logic                cycle_start;
  logic                cycle_end;
  scan_step_t          step;
  logic [PROD_W-1:0]   prod;

  // The result register frees up in the same cycle its item leaves.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign cycle_start = (count_q == '0);
  assign cycle_end   = (count_q == CNT_END);
  assign step        = scan_next(chan_q);
  assign prod        = PROD_W'(sum_q) * RECIP;

  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    chan_d      = chan_q;
    next_chan_d = next_chan_q;
    avg_valid_d = avg_valid_q;
    avg_chan_d  = avg_chan_q;
    avg_value_d = avg_value_q;
    if (accept) begin
      avg_valid_d = 1'b0;
      avg_chan_d  = CH_0;
      avg_value_d = '0;
      priority if (cycle_start) begin
        // The first reading of a cycle replaces the old sum.
        sum_d   = SUM_W'(sample_i);
        count_d = CNT_FIRST;
      end else if (cycle_end) begin
        // The closing reading is dropped; the average leaves with its channel.
        count_d = '0;
        chan_d  = step.next;
        if (step.stored) begin
          avg_valid_d = 1'b1;
          avg_chan_d  = chan_q;
          avg_value_d = prod[SHIFT +: SAMPLE_W];
        end
      end else begin
        sum_d   = sum_q + SUM_W'(sample_i);
        count_d = count_q + CNT_W'(1);
      end
      next_chan_d = chan_d;
    end
    if (cfg_we_i) begin
      chan_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      chan_q      <= CH_0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      chan_q  <= chan_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    next_chan_q <= next_chan_d;
    avg_valid_q <= avg_valid_d;
    avg_chan_q  <= avg_chan_d;
    avg_value_q <= avg_value_d;
  end

  assign out_valid_o       = out_valid_q;
  assign next_channel_o    = next_chan_q;
  assign average_valid_o   = avg_valid_q;
  assign average_channel_o = avg_chan_q;
  assign average_value_o   = avg_value_q;

  // The count never leaves its range 0 .. N+1.
  `ASSERT_AT(a_count_range, clk_i, rst_ni, count_q <= CNT_END, "scan count out of range")
  // A closing item always restarts the cycle.
  `ASSERT_AT(a_close_restarts, clk_i, rst_ni,
    (accept && cycle_end && !cfg_we_i) |=> (count_q == '0), "cycle did not restart")
  // Channels 4 and 5 never report an average.
  `ASSERT_NEVER_AT(a_no_skip_avg, clk_i, rst_ni,
    out_valid_q && avg_valid_q && (avg_chan_q == CH_4 || avg_chan_q == CH_5),
    "average reported for an unscanned channel")
  // A result without an average carries zero channel and value.
  `ASSERT_AT(a_empty_result, clk_i, rst_ni,
    (out_valid_q && !avg_valid_q) |-> (avg_chan_q == CH_0 && avg_value_q == '0),
    "empty result carries data")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for adc_scan_averager: random readings with random idling on both
// channels, checked against an in-bench prediction of the scan averager. Depends on asa_pkg.
module tb_top;
  import asa_pkg::*;

  // The block keeps its default number of readings per average.
  localparam int unsigned READINGS = READINGS_PER_AVERAGE_DEF;
  localparam int unsigned SUM_W = $clog2(READINGS * 255 + 1);
  // Cycles in which neither channel moves an item before the run is declared hung.
  // The longest stall or gap is far shorter, so this leaves a wide margin.
  localparam int unsigned IDLE_LIMIT = 2000;

  // One result item as the block presents it.
  typedef struct packed {
    logic [CHAN_W-1:0]   next_channel;
    logic                average_valid;
    logic [CHAN_W-1:0]   average_channel;
    logic [SAMPLE_W-1:0] average_value;
  } scan_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CHAN_W-1:0]   cfg_data_i  = CH_0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CHAN_W-1:0]   next_channel_o;
  logic                average_valid_o;
  logic [CHAN_W-1:0]   average_channel_o;
  logic [SAMPLE_W-1:0] average_value_o;

  // Predicted state of the averager: position in the scan cycle, running sum, mux channel
  // and the start channel register.
  int unsigned         reading_count;
  logic [SUM_W-1:0]    reading_sum;
  logic [CHAN_W-1:0]   current_channel;
  logic [CHAN_W-1:0]   start_channel;

  // Results predicted for accepted readings, oldest first.
  scan_result_t        expected_scans[$];
  int unsigned         mismatch_count = 0;
  // When set, neither side idles, so the block runs at full rate.
  bit                  steady_flow = 1'b0;
  int unsigned         stall_left = 0;

  adc_scan_averager #(
    .READINGS_PER_AVERAGE(READINGS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .next_channel_o    (next_channel_o),
    .average_valid_o   (average_valid_o),
    .average_channel_o (average_channel_o),
    .average_value_o   (average_value_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Length of an idle stretch: mostly none or a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_flow) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Advances the predicted state by one reading and returns the result it should give.
  // Each cycle sums READINGS readings; the reading after them closes the cycle and is
  // dropped, the average goes out with its channel, and the mux steps 0,1,2,3,6,7,0.
  // Channels 4 and 5 close without an average and fall back to channel 0.
  function automatic scan_result_t predict_scan_step(input logic [SAMPLE_W-1:0] reading);
    scan_result_t      res;
    logic              stored;
    logic [CHAN_W-1:0] follow;
    res = '0;
    if (reading_count == 0) begin
      reading_sum   = '0;
      reading_count = 1;
    end
    if (reading_count <= READINGS) begin
      reading_sum   = reading_sum + reading;
      reading_count = reading_count + 1;
    end else begin
      stored = 1'b1;
      case (current_channel)
        CH_0: follow = CH_1;
        CH_1: follow = CH_2;
        CH_2: follow = CH_3;
        CH_3: follow = CH_6;
        CH_6: follow = CH_7;
        CH_7: follow = CH_0;
        default: begin
          stored = 1'b0;
          follow = CH_0;
        end
      endcase
      reading_count = 0;
      if (stored) begin
        res.average_valid   = 1'b1;
        res.average_channel = current_channel;
        res.average_value   = SAMPLE_W'(reading_sum / READINGS);
      end
      current_channel = follow;
    end
    res.next_channel = current_channel;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Drives one reading after a random gap and waits until the block takes it. Inputs move
  // only at the falling edge; acceptance is judged from the values seen at the rising edge.
  task automatic send_reading(input logic [SAMPLE_W-1:0] reading);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= reading;
    do @(posedge clk_i); while (in_stall_o);
    expected_scans.push_back(predict_scan_step(reading));
  endtask

  // Stops sending and waits until every predicted result has come out, so that the block
  // is idle.
  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Writes the start channel while the block is idle. The mux takes it at once; the count
  // and the sum of a cycle in progress are kept.
  task automatic write_start_channel(input logic [CHAN_W-1:0] chan);
    wait_until_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= chan;
    @(posedge clk_i);
    start_channel   = chan;
    current_channel = chan;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Full-scale and zero readings on channel 0 straight after reset. The first cycle sums
  // 1020, the largest possible sum; the second sums 3, which truncates to an average of 0.
  // The dropped fifth reading is the opposite extreme in each case.
  task automatic test_extremes_after_reset();
    repeat (READINGS) send_reading(8'd255);
    send_reading(8'd0);
    repeat (READINGS - 1) send_reading(8'd0);
    send_reading(8'd3);
    send_reading(8'd255);
  endtask

  // Channels 4 and 5 are never reached by the scan, only by a register write. A cycle that
  // closes on one of them gives no average and jumps to channel 0.
  task automatic test_unscanned_channels();
    write_start_channel(CH_4);
    repeat (READINGS + 1) send_reading(8'($urandom_range(0, 255)));
    write_start_channel(CH_5);
    repeat (READINGS + 1) send_reading(8'($urandom_range(0, 255)));
  endtask

  // A write in the middle of a cycle moves the mux but keeps the partial sum, so the cycle
  // closes on the new channel with readings taken on the old one.
  task automatic test_midcycle_channel_write();
    send_reading(8'd200);
    send_reading(8'd17);
    write_start_channel(CH_7);
    repeat (READINGS - 1) send_reading(8'($urandom_range(0, 255)));
  endtask

  // Phases of random readings, each opened by a start channel write, both extremes of the
  // register among them. Some phases run without idling. Now and then the sender holds off
  // until every result is back, which leaves the block idle in mid-cycle.
  task automatic test_random_scans();
    logic [CHAN_W-1:0] chans[8];
    int unsigned       roll;
    logic [SAMPLE_W-1:0] reading;
    chans = '{CH_0, CH_7, CH_3, CH_4, CH_6, CH_5, CH_1, CH_2};
    for (int phase = 0; phase < 8; phase++) begin
      write_start_channel(chans[phase]);
      steady_flow = (phase == 2 || phase == 5);
      for (int n = 0; n < 78; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          reading = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        end else if (roll < 15) begin
          reading = 8'd1 << $urandom_range(0, 7);
        end else begin
          reading = 8'($urandom_range(0, 255));
        end
        send_reading(reading);
        if ($urandom_range(0, 59) == 0) begin
          wait_until_drained();
        end
      end
      steady_flow = 1'b0;
    end
  endtask

  // The receiver stalls at random: each falling edge either continues a stall or picks a
  // new stretch, so stalls land on every phase of the scan cycle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end else begin
        stall_left = pick_gap();
        if (stall_left != 0) begin
          out_stall_i <= 1'b1;
          stall_left = stall_left - 1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Every result taken from the block is checked field by field against the oldest
  // prediction. A result with nothing predicted is an error as well.
  always @(posedge clk_i) begin : check_results
    scan_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scans.size() == 0) begin
        report_mismatch("unexpected result item", 1, 0);
      end else begin
        want = expected_scans.pop_front();
        if (next_channel_o !== want.next_channel) begin
          report_mismatch("next_channel", next_channel_o, want.next_channel);
        end
        if (average_valid_o !== want.average_valid) begin
          report_mismatch("average_valid", average_valid_o, want.average_valid);
        end
        if (average_channel_o !== want.average_channel) begin
          report_mismatch("average_channel", average_channel_o, want.average_channel);
        end
        if (average_value_o !== want.average_value) begin
          report_mismatch("average_value", average_value_o, want.average_value);
        end
      end
    end
  end

  // Ends the run if neither channel moves an item for too long, which also catches
  // results that never arrive.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    reading_count   = 0;
    reading_sum     = '0;
    start_channel   = CH_0;
    current_channel = CH_0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extremes_after_reset();
    test_unscanned_channels();
    test_midcycle_channel_write();
    test_random_scans();

    // Let the last results out, then give stray items time to show up.
    wait_until_drained();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/asa_pkg.sv
src/adc_scan_averager.sv
sim/tb_top.sv
